// ===== hw/rtl/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

  // Default word width of the message, modulus, exponent and result.
  localparam int WordBits = 32;

  // Width of the configuration register index.
  localparam int CfgIdxBits = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CfgModulus  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgExponent = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } mexp_state_e;

endpackage

// ===== hw/rtl/mexp_reduce.sv =====
// Bit-serial reduction of a word modulo the modulus, one message bit per cycle.
`timescale 1ns / 1ps

module mexp_reduce #(
  parameter int WORD_BITS = mexp_pkg::WordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] value_i,
  input  logic [WORD_BITS-1:0] modulus_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] rem_o
);

  localparam int CntBits = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] val_q, val_d;
  logic [WORD_BITS-1:0] rem_q, rem_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS+1:0] diff;

  // The remainder stays below the modulus, so one conditional subtract per bit suffices.
  assign shifted = {rem_q, val_q[WORD_BITS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, modulus_i};

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      val_d  = value_i;
      rem_d  = '0;
      cnt_d  = CntBits'(WORD_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[WORD_BITS-2:0], 1'b0};
      rem_d = diff[WORD_BITS+1] ? shifted[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/mexp_mulmod.sv =====
// Bit-serial modular multiplier: a double step and an add step per multiplier bit.
`timescale 1ns / 1ps

module mexp_mulmod #(
  parameter int WORD_BITS = mexp_pkg::WordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  input  logic [WORD_BITS-1:0] modulus_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] product_o
);

  localparam int CntBits = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] a_q, a_d;
  logic [WORD_BITS-1:0] b_q, b_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 add_phase_q, add_phase_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [WORD_BITS-1:0] operand;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS+1:0] diff;

  // The double step adds the accumulator to itself; the add step adds a when the
  // current multiplier bit is set. Both operands are below the modulus.
  always_comb begin
    if (add_phase_q) begin
      operand = b_q[WORD_BITS-1] ? a_q : '0;
    end else begin
      operand = acc_q;
    end
  end

  assign sum  = {1'b0, acc_q} + {1'b0, operand};
  assign diff = {1'b0, sum} - {2'b00, modulus_i};

  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    add_phase_d = add_phase_q;
    busy_d      = busy_q;
    done_d      = 1'b0;
    if (start_i) begin
      a_d         = a_i;
      b_d         = b_i;
      acc_d       = '0;
      cnt_d       = CntBits'(WORD_BITS);
      add_phase_d = 1'b0;
      busy_d      = 1'b1;
    end else if (busy_q) begin
      acc_d       = diff[WORD_BITS+1] ? sum[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
      add_phase_d = !add_phase_q;
      if (add_phase_q) begin
        b_d   = {b_q[WORD_BITS-2:0], 1'b0};
        cnt_d = cnt_q - CntBits'(1);
        if (cnt_q == CntBits'(1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      cnt_q       <= '0;
      add_phase_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      done_q      <= done_d;
      cnt_q       <= cnt_d;
      add_phase_q <= add_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: sequencer, registers and handshakes.
`timescale 1ns / 1ps

// Computes message ^ exponent mod modulus for one message at a time, by
// left-to-right square-and-multiply over all WORD_BITS exponent bits. The
// message is first reduced modulo the modulus. Every exponent bit costs one
// squaring, and a set bit one more multiplication, each done in the shared
// bit-serial multiplier, so the time an item takes is set by the number of
// one bits in the exponent. A zero modulus gives a result of zero without a
// reduction or any multiplication. The finished result waits in an output
// register, and the next request is taken once the result has been loaded
// there. Modulus and exponent may be written only while no request is in
// flight.
module modular_exponentiation #(
  parameter int WORD_BITS = mexp_pkg::WordBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [WORD_BITS-1:0]            message_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [WORD_BITS-1:0]            power_mod_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mexp_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [WORD_BITS-1:0]            cfg_data_i
);

  localparam int CntBits = $clog2(WORD_BITS + 1);

  mexp_pkg::mexp_state_e state_q, state_d;

  logic [WORD_BITS-1:0] modulus_q, exponent_q;
  logic [WORD_BITS-1:0] res_q, res_d;
  logic [WORD_BITS-1:0] base_q, base_d;
  logic [WORD_BITS-1:0] exp_q, exp_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0] out_data_q, out_data_d;

  logic                 red_start, red_done;
  logic [WORD_BITS-1:0] red_rem;
  logic                 mul_start, mul_done;
  logic [WORD_BITS-1:0] mul_a, mul_b, mul_res;
  logic                 in_accept;
  logic                 mod_zero, mod_one;

  assign mod_zero  = (modulus_q == '0);
  assign mod_one   = (modulus_q == WORD_BITS'(1));
  assign in_accept = in_valid_i && !in_stall_o;

  assign in_stall_o  = (state_q != mexp_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= WORD_BITS'(1);
      exponent_q <= WORD_BITS'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == mexp_pkg::CfgModulus) begin
        modulus_q <= cfg_data_i;
      end else if (cfg_index_i == mexp_pkg::CfgExponent) begin
        exponent_q <= cfg_data_i;
      end
    end
  end

  mexp_reduce #(
    .WORD_BITS (WORD_BITS)
  ) u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (red_start),
    .value_i   (message_i),
    .modulus_i (modulus_q),
    .done_o    (red_done),
    .rem_o     (red_rem)
  );

  mexp_mulmod #(
    .WORD_BITS (WORD_BITS)
  ) u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .modulus_i (modulus_q),
    .done_o    (mul_done),
    .product_o (mul_res)
  );

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    base_d      = base_q;
    exp_d       = exp_q;
    cnt_d       = cnt_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    red_start   = 1'b0;
    mul_start   = 1'b0;
    mul_a       = mul_res;
    mul_b       = mul_res;

    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (mod_zero) begin
            res_d   = '0;
            state_d = mexp_pkg::ST_FINISH;
          end else begin
            red_start = 1'b1;
            res_d     = mod_one ? '0 : WORD_BITS'(1);
            exp_d     = exponent_q;
            cnt_d     = CntBits'(WORD_BITS);
            state_d   = mexp_pkg::ST_REDUCE;
          end
        end
      end

      mexp_pkg::ST_REDUCE: begin
        if (red_done) begin
          base_d    = red_rem;
          mul_start = 1'b1;
          mul_a     = res_q;
          mul_b     = res_q;
          state_d   = mexp_pkg::ST_SQUARE;
        end
      end

      mexp_pkg::ST_SQUARE: begin
        if (mul_done) begin
          res_d = mul_res;
          if (exp_q[WORD_BITS-1]) begin
            mul_start = 1'b1;
            mul_b     = base_q;
            state_d   = mexp_pkg::ST_MULT;
          end else begin
            exp_d = {exp_q[WORD_BITS-2:0], 1'b0};
            cnt_d = cnt_q - CntBits'(1);
            if (cnt_q == CntBits'(1)) begin
              state_d = mexp_pkg::ST_FINISH;
            end else begin
              mul_start = 1'b1;
            end
          end
        end
      end

      mexp_pkg::ST_MULT: begin
        if (mul_done) begin
          res_d = mul_res;
          exp_d = {exp_q[WORD_BITS-2:0], 1'b0};
          cnt_d = cnt_q - CntBits'(1);
          if (cnt_q == CntBits'(1)) begin
            state_d = mexp_pkg::ST_FINISH;
          end else begin
            mul_start = 1'b1;
            state_d   = mexp_pkg::ST_SQUARE;
          end
        end
      end

      mexp_pkg::ST_FINISH: begin
        // Hand the result over once the output register is free or being emptied.
        if (!out_valid_q || !out_stall_i) begin
          out_data_d  = res_q;
          out_valid_d = 1'b1;
          state_d     = mexp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    base_q     <= base_d;
    exp_q      <= exp_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign power_mod_o = out_data_q;

  // A delivered result is always reduced below a nonzero modulus.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mod_zero || (power_mod_o < modulus_q)))
    else $error("result not below modulus");

  // The multiplier only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == mexp_pkg::ST_SQUARE || state_q == mexp_pkg::ST_MULT))
    else $error("multiplier finished outside a multiply phase");

  // The reducer only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_done |-> (state_q == mexp_pkg::ST_REDUCE))
    else $error("reducer finished outside the reduce phase");

  // An accepted request blocks the input until its result has been handed over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input open right after a request was taken");

endmodule

// ===== test/modular_exponentiation_test.sv =====
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps

module modular_exponentiation_test;

  localparam int WB = mexp_pkg::WordBits;
  localparam int CycleLimit = 5_000_000;
  localparam int HoldCycles = 15_000;
  localparam int SettleCycles = 4_500;
  localparam int RandomPhases = 8;
  localparam int PhaseItems = 15;

  // Indexes the block decodes to no register; writes to them must be dropped.
  localparam logic [mexp_pkg::CfgIdxBits-1:0] CfgSpareLo = 2'd2;
  localparam logic [mexp_pkg::CfgIdxBits-1:0] CfgSpareHi = 2'd3;

  typedef logic [WB-1:0] word_t;

  typedef struct {
    word_t modulus;
    word_t exponent;
    word_t message;
    bit    known;
    word_t power_mod;
    bit    spare_writes;
  } directed_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  word_t                           message = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  word_t                           power_mod;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mexp_pkg::CfgIdxBits-1:0] cfg_index = mexp_pkg::CfgModulus;
  word_t                           cfg_data = '0;

  word_t         expected_powers[$];
  directed_row_t directed_rows[$];
  word_t         modulus_setting = 1;
  word_t         exponent_setting = 1;
  int            fail_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_left = 0;
  bit            hold_request = 1'b0;
  word_t         oldest;

  modular_exponentiation dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .message_i   (message),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .power_mod_o (power_mod),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  // Left-to-right square-and-multiply; the double-width product keeps each step exact.
  function automatic word_t expected_power(word_t msg, word_t expo, word_t modv);
    logic [2*WB-1:0] acc;
    logic [2*WB-1:0] base;
    logic [2*WB-1:0] modw;
    if (modv == '0) return '0;
    modw = (2*WB)'(modv);
    base = (2*WB)'(msg % modv);
    acc = (2*WB)'(1);
    acc = acc % modw;
    for (int i = WB - 1; i >= 0; i--) begin
      acc = (acc * acc) % modw;
      if (expo[i]) acc = (acc * base) % modw;
    end
    return acc[WB-1:0];
  endfunction

  function automatic word_t pick_message(word_t modv);
    unique case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return modv;
      3, 4: return (modv == '0) ? word_t'($urandom) : word_t'($urandom % modv);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(word_t m, word_t e, word_t msg, bit known, word_t res, bit spare);
    directed_row_t row;
    row.modulus = m;
    row.exponent = e;
    row.message = msg;
    row.known = known;
    row.power_mod = res;
    row.spare_writes = spare;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no second assignment per step.
  task automatic write_reg(logic [mexp_pkg::CfgIdxBits-1:0] idx, word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (expected_powers.size() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(word_t m, word_t e, bit spare);
    in_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    write_reg(mexp_pkg::CfgModulus, m);
    modulus_setting = m;
    write_reg(mexp_pkg::CfgExponent, e);
    exponent_setting = e;
    if (spare) begin
      write_reg(CfgSpareLo, '1);
      write_reg(CfgSpareHi, $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_message(word_t msg, bit known, word_t res);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    // Now and then a long pause, so that a new request lands anywhere in a computation.
    if ($urandom_range(999) < send_idle_pct) gap += $urandom_range(4400);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    message <= msg;
    do @(posedge clk); while (in_stall);
    expected_powers.insert(expected_powers.size(),
                           known ? res : expected_power(msg, exponent_setting,
                                                        modulus_setting));
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_powers.size() == 0) begin
        $error("power_mod: expected nothing, actual %h", power_mod);
        fail_count++;
      end else begin
        oldest = expected_powers.pop_front();
        if (power_mod !== oldest) begin
          $error("power_mod: expected %h, actual %h", oldest, power_mod);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("modular_exponentiation regression: fail");
      $finish;
    end
  end

  initial begin
    word_t m;
    word_t e;
    // The first rows run on the reset values of both registers.
    add_row(32'd1, 32'd1, 32'd5, 1'b1, 32'd0, 1'b0);
    add_row(32'd1, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0);
    add_row(32'd0, 32'd5, 32'd123, 1'b1, 32'd0, 1'b0);
    add_row(32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0);
    add_row(32'd1000, 32'd0, 32'd0, 1'b1, 32'd1, 1'b0);
    add_row(32'd1000, 32'd0, 32'd12345, 1'b1, 32'd1, 1'b0);
    add_row(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd1, 1'b0);
    add_row(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0);
    add_row(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE, 1'b0);
    add_row(32'hFFFF_FFFF, 32'd2, 32'h0001_0000, 1'b1, 32'd1, 1'b0);
    add_row(32'd97, 32'd1, 32'd1000, 1'b1, 32'd30, 1'b0);
    add_row(32'd3233, 32'd17, 32'd65, 1'b1, 32'd2790, 1'b1);
    add_row(32'd3233, 32'd17, 32'd3233, 1'b1, 32'd0, 1'b0);
    add_row(32'd3233, 32'd2753, 32'd2790, 1'b1, 32'd65, 1'b0);
    add_row(32'hFFFF_FFFB, 32'hFFFF_FFFA, 32'd2, 1'b1, 32'd1, 1'b0);
    add_row(32'd2, 32'hFFFF_FFFF, 32'd3, 1'b1, 32'd1, 1'b0);
    add_row(32'h8000_0000, 32'd31, 32'd2, 1'b1, 32'd0, 1'b0);
    add_row(32'h8000_0000, 32'd30, 32'd2, 1'b1, 32'h4000_0000, 1'b0);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0, 1'b0);
    add_row(32'd1000003, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b0, '0, 1'b0);
    add_row(32'hFFFF_FFFE, 32'd65537, 32'h1234_5678, 1'b0, '0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 56;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].modulus != modulus_setting ||
          directed_rows[i].exponent != exponent_setting || directed_rows[i].spare_writes) begin
        apply_settings(directed_rows[i].modulus, directed_rows[i].exponent,
                       directed_rows[i].spare_writes);
      end
      send_message(directed_rows[i].message, directed_rows[i].known,
                   directed_rows[i].power_mod);
    end

    for (int phase = 0; phase < RandomPhases; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 56;
      end else if (phase < 6) begin
        send_idle_pct = 56;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      m = $urandom;
      e = $urandom;
      unique case (phase)
        1: begin
          m = '1;
          e = '1;
        end
        2: m = $urandom_range(65535, 2);
        3: m = '0;
        4: begin
          m = m | 32'h8000_0000;
          e = '0;
        end
        5: m = 32'd1;
        6: e = $urandom & $urandom & $urandom;
        default: ;
      endcase
      apply_settings(m, e, 1'($urandom_range(1)));
      // The output side holds off long enough for the block to fill and stall requests.
      if (phase == RandomPhases - 1) hold_request = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        send_message(pick_message(modulus_setting), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("modular_exponentiation regression: pass");
    end else begin
      $display("modular_exponentiation regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_reduce.sv
hw/rtl/mexp_mulmod.sv
hw/rtl/modular_exponentiation.sv
test/modular_exponentiation_test.sv
